// File: rtl/riot_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RAM, I/O port and timer block.
// No dependencies; riot_ctrl, the top level and the bench import this package.
package riot_pkg;

  localparam int RIOT_RAM_DEPTH = 256;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_RAM_RD = 3'd1;
  localparam logic [2:0] MODE_RAM_WR = 3'd2;
  localparam logic [2:0] MODE_IO_RD  = 3'd3;
  localparam logic [2:0] MODE_IO_WR  = 3'd4;

  localparam logic [2:0] REG_CMD     = 3'd0;
  localparam logic [2:0] REG_PORT_A  = 3'd1;
  localparam logic [2:0] REG_PORT_B  = 3'd2;
  localparam logic [2:0] REG_PORT_C  = 3'd3;
  localparam logic [2:0] REG_TMR_LO  = 3'd4;
  localparam logic [2:0] REG_TMR_HI  = 3'd5;

  localparam logic [1:0] CMD_NOP     = 2'b00;
  localparam logic [1:0] CMD_STOP    = 2'b01;
  localparam logic [1:0] CMD_STOP_TC = 2'b10;
  localparam logic [1:0] CMD_START   = 2'b11;

  localparam logic [1:0] PC_INPUT    = 2'b00;
  localparam logic [1:0] PC_OUTPUT   = 2'b11;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [7:0] latch_a;
    logic       drive_a;
    logic [7:0] latch_b;
    logic       drive_b;
    logic [5:0] latch_c;
    logic       drive_c;
    logic       timer_pin;
  } stat_t;

endpackage

// File: rtl/riot_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module riot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/riot_ctrl.sv
`timescale 1ns / 1ps
// Command, port latch and 14-bit timer registers with the I/O read path.
// Depends on riot_pkg.
module riot_ctrl
  import riot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [2:0] mode,
  input  logic [2:0] reg_sel,
  input  logic [7:0] wdata,
  input  logic [7:0] pin_a,
  input  logic [7:0] pin_b,
  input  logic [5:0] pin_c,
  output logic [7:0] io_rdata,
  output stat_t      stat_nxt
);

  logic [7:0]  cmd_r,     cmd_nxt;
  logic        tc_r,      tc_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] ld_r,      ld_nxt;
  logic [13:0] hr_r,      hr_nxt;
  logic [12:0] pr_r,      pr_nxt;
  logic        pa_r,      pa_nxt;
  logic        run_r,     run_nxt;
  logic        even_r,    even_nxt;
  logic        lvl_r,     lvl_nxt;
  logic [7:0]  la_r,      la_nxt;
  logic [7:0]  lb_r,      lb_nxt;
  logic [5:0]  lc_r,      lc_nxt;

  function automatic logic [13:0] count_f(input logic run, input logic [13:0] hr,
                                          input logic [15:0] ld, input logic even,
                                          input logic [15:0] len);
    logic [14:0] c;
    logic [14:0] lim;
    begin
      c   = {hr, 1'b0};
      lim = {1'b0, ld[13:1], 1'b0};
      if (c > lim) begin
        c = lim;
      end
      c[0] = ~even;
      count_f = run ? c[13:0] : len[13:0];
    end
  endfunction

  logic [13:0] cur_cnt;
  assign cur_cnt = count_f(run_r, hr_r, ld_r, even_r, len_r);

  always_comb begin
    logic [13:0] span;
    cmd_nxt  = cmd_r;
    tc_nxt   = tc_r;
    len_nxt  = len_r;
    ld_nxt   = ld_r;
    hr_nxt   = hr_r;
    pr_nxt   = pr_r;
    pa_nxt   = pa_r;
    run_nxt  = run_r;
    even_nxt = even_r;
    lvl_nxt  = lvl_r;
    la_nxt   = la_r;
    lb_nxt   = lb_r;
    lc_nxt   = lc_r;
    io_rdata = 8'h00;
    span     = {ld_r[13:1], 1'b0};
    if (acc) begin
      unique case (mode)
        MODE_TICK: begin
          if (run_r) begin
            if (pa_r) begin
              pr_nxt = (pr_r != 13'd0) ? pr_r - 13'd1 : 13'd0;
              if (pr_nxt == 13'd0) begin
                if (ld_r[15]) lvl_nxt = 1'b0;
                tc_nxt = 1'b1;
                pa_nxt = 1'b0;
              end
            end
            hr_nxt = (hr_r != 14'd0) ? hr_r - 14'd1 : 14'd0;
            if (hr_nxt == 14'd0) begin
              if (even_r) begin
                lvl_nxt  = 1'b1;
                even_nxt = 1'b0;
                tc_nxt   = 1'b1;
                if (!ld_r[14] || cmd_r[7:6] == CMD_STOP_TC) begin
                  run_nxt = 1'b0;
                  pa_nxt  = 1'b0;
                end else if (len_r[13:0] < 14'd2) begin
                  ld_nxt  = {len_r[15:14], 14'd1};
                  run_nxt = 1'b0;
                  pa_nxt  = 1'b0;
                end else begin
                  ld_nxt  = len_r;
                  hr_nxt  = {1'b0, len_r[13:1]} + {13'd0, len_r[0]};
                  run_nxt = 1'b1;
                  pa_nxt  = 1'b0;
                end
              end else begin
                hr_nxt   = {1'b0, span[13:1]};
                even_nxt = 1'b1;
                if (!ld_r[15]) begin
                  lvl_nxt = 1'b0;
                end else begin
                  pr_nxt = (span < 14'd2) ? 13'd0 : span[13:1] - 13'd1;
                  pa_nxt = 1'b1;
                  if (pr_nxt == 13'd0) begin
                    lvl_nxt = 1'b0;
                    tc_nxt  = 1'b1;
                    pa_nxt  = 1'b0;
                  end
                end
              end
            end
          end
        end
        MODE_IO_RD: begin
          unique case (reg_sel)
            REG_CMD: begin
              io_rdata = {1'b0, tc_r, 6'd0};
              tc_nxt   = 1'b0;
            end
            REG_PORT_A: io_rdata = cmd_r[0] ? la_r : pin_a;
            REG_PORT_B: io_rdata = cmd_r[1] ? lb_r : pin_b;
            REG_PORT_C: begin
              unique case (cmd_r[3:2])
                PC_INPUT:  io_rdata = {2'b11, pin_c};
                PC_OUTPUT: io_rdata = {2'b11, lc_r};
                default:   io_rdata = 8'hc0;
              endcase
            end
            REG_TMR_LO: io_rdata = cur_cnt[7:0];
            REG_TMR_HI: io_rdata = {ld_r[15:14], cur_cnt[13:8]};
            default:    io_rdata = 8'h00;
          endcase
        end
        MODE_IO_WR: begin
          unique case (reg_sel)
            REG_CMD: begin
              cmd_nxt = wdata;
              unique case (wdata[7:6])
                CMD_STOP: begin
                  if (run_r) ld_nxt = {ld_r[15:14], cur_cnt};
                  run_nxt = 1'b0;
                  pa_nxt  = 1'b0;
                  lvl_nxt = 1'b1;
                end
                CMD_START: begin
                  if (!run_r) begin
                    ld_nxt  = len_r;
                    pa_nxt  = 1'b0;
                    lvl_nxt = 1'b1;
                    if (len_r[13:0] >= 14'd2) begin
                      even_nxt = 1'b0;
                      hr_nxt   = {1'b0, len_r[13:1]} + {13'd0, len_r[0]};
                      run_nxt  = 1'b1;
                    end
                  end
                end
                default: ;
              endcase
            end
            REG_PORT_A: la_nxt = wdata;
            REG_PORT_B: lb_nxt = wdata;
            REG_PORT_C: lc_nxt = wdata[5:0];
            REG_TMR_LO: len_nxt = {len_r[15:8], wdata};
            REG_TMR_HI: len_nxt = {wdata, len_r[7:0]};
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= '0;
      tc_r   <= 1'b0;
      len_r  <= '0;
      ld_r   <= '0;
      hr_r   <= '0;
      pr_r   <= '0;
      pa_r   <= 1'b0;
      run_r  <= 1'b0;
      even_r <= 1'b0;
      lvl_r  <= 1'b1;
      la_r   <= '0;
      lb_r   <= '0;
      lc_r   <= '0;
    end else begin
      cmd_r  <= cmd_nxt;
      tc_r   <= tc_nxt;
      len_r  <= len_nxt;
      ld_r   <= ld_nxt;
      hr_r   <= hr_nxt;
      pr_r   <= pr_nxt;
      pa_r   <= pa_nxt;
      run_r  <= run_nxt;
      even_r <= even_nxt;
      lvl_r  <= lvl_nxt;
      la_r   <= la_nxt;
      lb_r   <= lb_nxt;
      lc_r   <= lc_nxt;
    end
  end

  assign stat_nxt.latch_a   = la_nxt;
  assign stat_nxt.drive_a   = cmd_nxt[0];
  assign stat_nxt.latch_b   = lb_nxt;
  assign stat_nxt.drive_b   = cmd_nxt[1];
  assign stat_nxt.latch_c   = lc_nxt;
  assign stat_nxt.drive_c   = (cmd_nxt[3:2] == PC_OUTPUT);
  assign stat_nxt.timer_pin = lvl_nxt;

`ifndef SYNTHESIS
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (ld_r[13:0] >= 14'd2))
    else $error("Timer running with a count below two.");
  a_run_half: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (hr_r != 14'd0))
    else $error("Timer running with an empty half.");
  a_pulse_arm: assert property (@(posedge clk) disable iff (!rst_n)
    pa_r |-> (run_r && even_r))
    else $error("Pulse armed outside the even half of a running count.");
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> lvl_r)
    else $error("Timer output low while the timer is stopped.");
`endif

endmodule

// File: rtl/ram_io_port_timer_device.sv
`timescale 1ns / 1ps
// Top level of the RAM, I/O port and timer block: stream ports, pipeline and RAM.
// Depends on riot_pkg, riot_ram and riot_ctrl.
//
// The block takes one transaction per clock and returns one result per transaction.
// Each result passes the pipeline stage, where the RAM read data is registered, and then
// the output register. Register and timer updates complete in the cycle of
// acceptance, so back-to-back transactions of any mix run at one per clock; the
// input side stalls only while the output register holds a result not yet taken.
// The RAM needs no initialization; a read of a byte never written returns an
// undefined value.
module ram_io_port_timer_device
  import riot_pkg::*;
#(
  parameter int RAM_DEPTH = RIOT_RAM_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: mode[2:0], address[7:0], write_data[7:0], pin_a_in[7:0],
  // pin_b_in[7:0], pin_c_in[5:0], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: read_data[7:0], latch_a_out[7:0], drive_a, latch_b_out[7:0],
  // drive_b, latch_c_out[5:0], drive_c, timer_pin, zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(RAM_DEPTH);

  logic [2:0] in_mode;
  logic [7:0] in_address;
  logic [7:0] in_write_data;
  logic [7:0] in_pin_a;
  logic [7:0] in_pin_b;
  logic [5:0] in_pin_c;

  assign in_mode       = in_tdata[2:0];
  assign in_address    = in_tdata[10:3];
  assign in_write_data = in_tdata[18:11];
  assign in_pin_a      = in_tdata[26:19];
  assign in_pin_b      = in_tdata[34:27];
  assign in_pin_c      = in_tdata[40:35];

  logic adv;
  logic acc;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  logic [AW-1:0] addr_map [256];
  for (genvar i = 0; i < 256; i++) begin : g_addr_map
    assign addr_map[i] = AW'(i % RAM_DEPTH);
  end

  logic [7:0] ram_rdata;

  riot_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (acc && (in_mode == MODE_RAM_WR)),
    .re    (acc && (in_mode == MODE_RAM_RD)),
    .addr  (addr_map[in_address]),
    .wdata (in_write_data),
    .rdata (ram_rdata)
  );

  logic [7:0] io_rdata;
  stat_t      stat_nxt;

  riot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .mode     (in_mode),
    .reg_sel  (in_address[2:0]),
    .wdata    (in_write_data),
    .pin_a    (in_pin_a),
    .pin_b    (in_pin_b),
    .pin_c    (in_pin_c),
    .io_rdata (io_rdata),
    .stat_nxt (stat_nxt)
  );

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_ram_r;
  logic [7:0]            s1_rd_r;
  stat_t                 s1_stat_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [7:0]            rd_sel;

  assign s1_valid_nxt  = adv ? acc : s1_valid_r;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  assign rd_sel        = s1_ram_r ? ram_rdata : s1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ram_r  <= (in_mode == MODE_RAM_RD);
      s1_rd_r   <= io_rdata;
      s1_stat_r <= stat_nxt;
    end
    if (adv && s1_valid_r) begin
      out_data_r <= {6'd0, s1_stat_r.timer_pin, s1_stat_r.drive_c, s1_stat_r.latch_c,
                     s1_stat_r.drive_b, s1_stat_r.latch_b, s1_stat_r.drive_a,
                     s1_stat_r.latch_a, rd_sel};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_stat_r) && $stable(s1_rd_r)))
    else $error("Pending result changed while the pipeline was stalled.");
  a_no_acc_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !acc)
    else $error("Transaction accepted while the output register was blocked.");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> out_valid_r)
    else $error("Result lost between the pipeline stage and the output register.");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ram_io_port_timer_device: directed and random streams of timer
// ticks, RAM accesses and I/O register accesses, each result checked against a predictor.
// Depends on riot_pkg and the RTL of ram_io_port_timer_device.
module tb
  import riot_pkg::*;
();

  localparam int WATCHDOG_NS  = 2_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_EVERY  = 250;
  localparam int END_CYCLES   = 8;

  localparam logic [15:0] SPAN_MASK  = 16'h3ffe;
  localparam logic [15:0] COUNT_MASK = 16'h3fff;
  localparam logic [15:0] MODE_MASK  = 16'hc000;

  localparam logic [2:0] REG_SPARE_LO     = 3'd6;
  localparam logic [2:0] REG_SPARE_HI     = 3'd7;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  always #2 clk = ~clk;

  ram_io_port_timer_device dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [7:0]  mem_img [RIOT_RAM_DEPTH];
  bit          mem_valid [RIOT_RAM_DEPTH];
  logic [7:0]  addr_written[$];
  logic [7:0]  cmd_q = '0;
  logic        tc_seen = 1'b0;
  logic [15:0] len_q = '0;
  logic [15:0] cnt_load = '0;
  logic [15:0] half_left = '0;
  logic [15:0] pulse_left = '0;
  logic        pulse_on = 1'b0;
  logic        tmr_run = 1'b0;
  logic        tmr_even = 1'b0;
  logic        tmr_out = 1'b1;
  logic [7:0]  a_latch = '0;
  logic [7:0]  b_latch = '0;
  logic [5:0]  c_latch = '0;

  logic [OUT_DATA_W-1:0] pending_results[$];
  int  fail_count = 0;
  int  results_seen = 0;
  int  tc_events = 0;
  int  tick_count = 0;
  int  ram_count = 0;
  int  io_count = 0;
  int  other_count = 0;
  int  timer_runs = 0;
  bit  steady = 1'b0;
  int  stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int ram_slot(input logic [7:0] adr);
    return int'(adr) % RIOT_RAM_DEPTH;
  endfunction

  function automatic logic [7:0] reg_byte(input logic [2:0] sel);
    return {5'd0, sel};
  endfunction

  function automatic logic [15:0] live_count();
    logic [16:0] c;
    logic [16:0] lim;
    if (!tmr_run) return len_q;
    c = {half_left, 1'b0};
    lim = {1'b0, cnt_load & SPAN_MASK};
    if (c > lim) c = lim;
    if (!tmr_even) c[0] = 1'b1;
    return c[15:0];
  endfunction

  function automatic void halt_count();
    if (tmr_run) cnt_load = (cnt_load & MODE_MASK) | live_count();
    tmr_run = 1'b0;
    pulse_on = 1'b0;
    tmr_out = 1'b1;
  endfunction

  function automatic void restart_count();
    cnt_load = len_q;
    if ((len_q & COUNT_MASK) < 16'd2) begin
      halt_count();
    end else begin
      tmr_even = 1'b0;
      half_left = ((len_q & SPAN_MASK) >> 1) + {15'd0, len_q[0]};
      tmr_run = 1'b1;
      pulse_on = 1'b0;
      tmr_out = 1'b1;
    end
  endfunction

  function automatic void fire_pulse();
    if (cnt_load[15]) tmr_out = 1'b0;
    tc_seen = 1'b1;
    tc_events++;
    pulse_on = 1'b0;
  endfunction

  function automatic void finish_half();
    logic [15:0] span;
    if (tmr_even) begin
      tmr_out = 1'b1;
      tmr_even = 1'b0;
      tc_seen = 1'b1;
      tc_events++;
      if (!cnt_load[14] || cmd_q[7:6] == CMD_STOP_TC) begin
        tmr_run = 1'b0;
        pulse_on = 1'b0;
      end else begin
        restart_count();
      end
    end else begin
      span = cnt_load & SPAN_MASK;
      half_left = span >> 1;
      tmr_even = 1'b1;
      if (!cnt_load[15]) begin
        tmr_out = 1'b0;
      end else begin
        if (span < 16'd2) span = 16'd2;
        pulse_left = (span - 16'd2) >> 1;
        pulse_on = 1'b1;
        if (pulse_left == 0) fire_pulse();
      end
    end
  endfunction

  function automatic void tick_timer();
    if (tmr_run) begin
      if (pulse_on) begin
        if (pulse_left > 0) pulse_left--;
        if (pulse_left == 0) fire_pulse();
      end
      if (half_left > 0) half_left--;
      if (half_left == 0) finish_half();
    end
  endfunction

  function automatic void write_cmd(input logic [7:0] d);
    cmd_q = d;
    case (d[7:6])
      CMD_STOP: halt_count();
      CMD_START: if (!tmr_run) restart_count();
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] read_io(input logic [2:0] sel, input logic [7:0] pa,
                                         input logic [7:0] pb, input logic [5:0] pc);
    logic [7:0]  v;
    logic [15:0] cur;
    v = '0;
    cur = live_count();
    case (sel)
      REG_CMD: begin
        v = {1'b0, tc_seen, 6'b0};
        tc_seen = 1'b0;
      end
      REG_PORT_A: v = cmd_q[0] ? a_latch : pa;
      REG_PORT_B: v = cmd_q[1] ? b_latch : pb;
      REG_PORT_C: begin
        if (cmd_q[3:2] == PC_OUTPUT) v = {2'b11, c_latch};
        else if (cmd_q[3:2] == PC_INPUT) v = {2'b11, pc};
        else v = 8'hc0;
      end
      REG_TMR_LO: v = cur[7:0];
      REG_TMR_HI: v = {cnt_load[15:14], cur[13:8]};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic void write_io(input logic [2:0] sel, input logic [7:0] d);
    case (sel)
      REG_CMD: write_cmd(d);
      REG_PORT_A: a_latch = d;
      REG_PORT_B: b_latch = d;
      REG_PORT_C: c_latch = d[5:0];
      REG_TMR_LO: len_q[7:0] = d;
      REG_TMR_HI: len_q[15:8] = d;
      default: ;
    endcase
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_result(input logic [IN_DATA_W-1:0] item);
    logic [2:0] op;
    logic [7:0] adr;
    logic [7:0] wd;
    logic [7:0] rd;
    op = item[2:0];
    adr = item[10:3];
    wd = item[18:11];
    rd = '0;
    case (op)
      MODE_TICK: tick_timer();
      MODE_RAM_RD: rd = mem_img[ram_slot(adr)];
      MODE_RAM_WR: begin
        mem_img[ram_slot(adr)] = wd;
        if (!mem_valid[ram_slot(adr)]) begin
          mem_valid[ram_slot(adr)] = 1'b1;
          addr_written.push_back(adr);
        end
      end
      MODE_IO_RD: rd = read_io(adr[2:0], item[26:19], item[34:27], item[40:35]);
      MODE_IO_WR: write_io(adr[2:0], wd);
      default: ;
    endcase
    return {6'b0, tmr_out, cmd_q[3:2] == PC_OUTPUT, c_latch, cmd_q[1], b_latch, cmd_q[0],
            a_latch, rd};
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_item(input logic [2:0] op,
      input logic [7:0] adr, input logic [7:0] wd, input logic [7:0] pa,
      input logic [7:0] pb, input logic [5:0] pc);
    logic [IN_DATA_W-1:0] it;
    it = '0;
    it[2:0] = op;
    it[10:3] = adr;
    it[18:11] = wd;
    it[26:19] = pa;
    it[34:27] = pb;
    it[40:35] = pc;
    return it;
  endfunction

  function automatic logic [7:0] reg_addr(input logic [2:0] sel);
    logic [7:0] b;
    b = 8'($urandom);
    return {b[7:3], sel};
  endfunction

  function automatic void check_field(input string name, input logic [7:0] e,
                                      input logic [7:0] g);
    if (e !== g) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, g);
      fail_count++;
    end
  endfunction

  task automatic send_item(input logic [IN_DATA_W-1:0] item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_result(item));
    case (item[2:0])
      MODE_TICK: tick_count++;
      MODE_RAM_RD, MODE_RAM_WR: ram_count++;
      MODE_IO_RD, MODE_IO_WR: io_count++;
      default: other_count++;
    endcase
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] adr, input logic [7:0] wd);
    send_item(make_item(op, adr, wd, 8'($urandom), 8'($urandom), 6'($urandom)));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
    else stall_left = pick_gap();
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction 0x%0h arrived with nothing expected", out_tdata);
        fail_count++;
      end else begin
        logic [OUT_DATA_W-1:0] exp;
        exp = pending_results.pop_front();
        results_seen++;
        check_field("read_data", exp[7:0], out_tdata[7:0]);
        check_field("latch_a_out", exp[15:8], out_tdata[15:8]);
        check_field("drive_a", 8'(exp[16]), 8'(out_tdata[16]));
        check_field("latch_b_out", exp[24:17], out_tdata[24:17]);
        check_field("drive_b", 8'(exp[25]), 8'(out_tdata[25]));
        check_field("latch_c_out", 8'(exp[31:26]), 8'(out_tdata[31:26]));
        check_field("drive_c", 8'(exp[32]), 8'(out_tdata[32]));
        check_field("timer_pin", 8'(exp[33]), 8'(out_tdata[33]));
      end
    end
  end

  task automatic test_ram_access();
    send_op(MODE_RAM_WR, 8'h00, 8'hff);
    send_op(MODE_RAM_WR, 8'hff, 8'h00);
    send_op(MODE_RAM_RD, 8'h00, 8'h00);
    send_op(MODE_RAM_RD, 8'hff, 8'hff);
  endtask

  task automatic test_port_modes();
    send_item(make_item(MODE_IO_WR, reg_byte(REG_CMD), 8'h0f, 8'h00, 8'h00, 6'h00));
    send_item(make_item(MODE_IO_WR, reg_byte(REG_PORT_A), 8'hff, 8'h00, 8'h00, 6'h00));
    send_item(make_item(MODE_IO_WR, reg_byte(REG_PORT_C), 8'hff, 8'h00, 8'h00, 6'h00));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_A), 8'h00, 8'h00, 8'hff, 6'h00));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_C), 8'h00, 8'h00, 8'h00, 6'h00));
    send_item(make_item(MODE_IO_WR, reg_byte(REG_CMD), 8'h04, 8'hff, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_C), 8'h00, 8'hff, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_WR, reg_byte(REG_CMD), 8'h08, 8'hff, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_C), 8'h00, 8'hff, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_WR, reg_byte(REG_CMD), 8'h00, 8'hff, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_A), 8'h00, 8'hff, 8'h00, 6'h3f));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_B), 8'h00, 8'h00, 8'hff, 6'h3f));
    send_item(make_item(MODE_IO_RD, reg_byte(REG_PORT_C), 8'h00, 8'h00, 8'h00, 6'h3f));
  endtask

  task automatic test_timer_modes();
    send_op(MODE_IO_WR, reg_byte(REG_TMR_LO), 8'h02);
    send_op(MODE_IO_WR, reg_byte(REG_TMR_HI), 8'h80);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_START, 6'h00});
    repeat (2) send_op(MODE_TICK, 8'h00, 8'h00);
    send_op(MODE_IO_RD, reg_byte(REG_CMD), 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_TMR_LO), 8'h05);
    send_op(MODE_IO_WR, reg_byte(REG_TMR_HI), 8'h40);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_START, 6'h00});
    repeat (2) send_op(MODE_TICK, 8'h00, 8'h00);
    send_op(MODE_IO_RD, reg_byte(REG_TMR_LO), 8'h00);
    send_op(MODE_IO_RD, reg_byte(REG_TMR_HI), 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_STOP_TC, 6'h00});
    repeat (3) send_op(MODE_TICK, 8'h00, 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_START, 6'h00});
    send_op(MODE_TICK, 8'h00, 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_STOP, 6'h00});
    send_op(MODE_IO_RD, reg_byte(REG_TMR_HI), 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_TMR_LO), 8'h01);
    send_op(MODE_IO_WR, reg_byte(REG_TMR_HI), 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_CMD), {CMD_START, 6'h00});
    send_op(MODE_IO_RD, reg_byte(REG_TMR_LO), 8'h00);
  endtask

  task automatic test_unused_codes();
    send_op(MODE_IO_RD, reg_byte(REG_SPARE_LO), 8'h00);
    send_op(MODE_IO_WR, reg_byte(REG_SPARE_HI), 8'hff);
    send_op(MODE_SPARE_FIRST, 8'hff, 8'hff);
    send_op(MODE_SPARE_MID, 8'h00, 8'h00);
    send_op(MODE_SPARE_LAST, 8'hff, 8'hff);
  endtask

  task automatic test_random_traffic();
    int n;
    int k;
    int pick;
    int next_drain;
    logic [13:0] span;
    logic [7:0] b;
    logic [7:0] adr;
    logic [2:0] op;
    n = 0;
    next_drain = DRAIN_EVERY;
    while (n < RANDOM_ITEMS) begin
      steady = ((n / 150) % 3) == 2;
      if (n >= next_drain) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0: span = 14'($urandom_range(0, 1));
          1: span = 14'($urandom);
          default: span = 14'($urandom_range(2, 40));
        endcase
        b = 8'($urandom);
        send_op(MODE_IO_WR, reg_addr(REG_TMR_LO), span[7:0]);
        send_op(MODE_IO_WR, reg_addr(REG_TMR_HI), {b[7:6], span[13:8]});
        send_op(MODE_IO_WR, reg_addr(REG_CMD), {CMD_START, b[5:0]});
        timer_runs++;
        n += 3;
        k = $urandom_range(4, 80);
        repeat (k) begin
          pick = $urandom_range(0, 99);
          b = 8'($urandom);
          if (pick < 75) begin
            send_op(MODE_TICK, 8'($urandom), 8'($urandom));
          end else if (pick < 90) begin
            case ($urandom_range(0, 2))
              0: send_op(MODE_IO_RD, reg_addr(REG_CMD), b);
              1: send_op(MODE_IO_RD, reg_addr(REG_TMR_LO), b);
              default: send_op(MODE_IO_RD, reg_addr(REG_TMR_HI), b);
            endcase
          end else if (pick < 96) begin
            send_op(MODE_IO_WR, reg_addr(REG_CMD), b);
          end else begin
            send_op(MODE_IO_WR, reg_addr(pick[0] ? REG_TMR_LO : REG_TMR_HI), b);
          end
          n++;
        end
      end else if (pick < 65) begin
        k = $urandom_range(3, 10);
        repeat (k) begin
          b = 8'($urandom);
          case ($urandom_range(0, 6))
            0: send_op(MODE_IO_WR, reg_addr(REG_CMD), {CMD_NOP, b[5:0]});
            1: send_op(MODE_IO_WR, reg_addr(REG_PORT_A), b);
            2: send_op(MODE_IO_WR, reg_addr(REG_PORT_B), b);
            3: send_op(MODE_IO_WR, reg_addr(REG_PORT_C), b);
            4: send_op(MODE_IO_RD, reg_addr(REG_PORT_A), b);
            5: send_op(MODE_IO_RD, reg_addr(REG_PORT_B), b);
            default: send_op(MODE_IO_RD, reg_addr(REG_PORT_C), b);
          endcase
          n++;
        end
      end else if (pick < 85) begin
        k = $urandom_range(2, 12);
        repeat (k) begin
          if ($urandom_range(0, 1) == 0) begin
            send_op(MODE_RAM_WR, 8'($urandom), 8'($urandom));
          end else begin
            adr = addr_written[$urandom_range(0, addr_written.size() - 1)];
            send_op(MODE_RAM_RD, adr, 8'($urandom));
          end
          n++;
        end
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          op = ($urandom_range(0, 49) == 0) ?
               3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)) :
               3'($urandom_range(MODE_TICK, MODE_IO_WR));
          adr = 8'($urandom);
          if (op == MODE_RAM_RD && !mem_valid[ram_slot(adr)])
            adr = addr_written[$urandom_range(0, addr_written.size() - 1)];
          send_op(op, adr, 8'($urandom));
          n++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ram_access();
    test_port_modes();
    test_timer_modes();
    test_unused_codes();
    test_random_traffic();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d transactions: %0d ticks, %0d RAM, %0d I/O, %0d unused modes.",
             tick_count + ram_count + io_count + other_count, tick_count, ram_count,
             io_count, other_count);
    $display("Checked %0d results over %0d random timer runs with %0d terminal counts.",
             results_seen, timer_runs, tc_events);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS ram_io_port_timer_device");
    end else begin
      $display("FAIL ram_io_port_timer_device");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("FAIL ram_io_port_timer_device");
    $finish;
  end

endmodule

// File: filelist.f
rtl/riot_pkg.sv
rtl/riot_ram.sv
rtl/riot_ctrl.sv
rtl/ram_io_port_timer_device.sv
bench/tb.sv
